// ===== rtl/uule_pkg.sv =====
// Shared types and constants for the uuencode line encoder.
`default_nettype none
package uule_pkg;

	// Characters per encoded line body, and the byte count that closes a line
	localparam int LINE_CHARS = 60;
	localparam int STORE_DEPTH = 45;
	localparam int LINE_BYTES_RAW = (LINE_CHARS / 4) * 3;
	localparam int LINE_BYTES = (LINE_BYTES_RAW < 3) ? 3 :
		((LINE_BYTES_RAW > STORE_DEPTH) ? STORE_DEPTH : LINE_BYTES_RAW);

	// Byte index within a line, and store address (line buffer select plus index)
	localparam int CNT_W = 6;
	localparam int ADDR_W = CNT_W + 1;
	localparam logic [CNT_W-1:0] LINE_LEN = CNT_W'(LINE_BYTES);

	// Output character codes
	localparam logic [6:0] CH_SPACE = 7'd32;
	localparam logic [6:0] CH_NEWLINE = 7'd10;
	localparam logic [6:0] CH_BACKTICK = 7'd96;

	// One closed line waiting to be encoded
	typedef struct packed {
		logic bank;
		logic [CNT_W-1:0] count;
		logic last;
	} job_t;

	// Line store write port
	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		logic [7:0] data;
	} wr_t;

	// Line buffer handed back by the encoder
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage
`default_nettype wire

// ===== rtl/uule_store.sv =====
// Double line store: two line buffers in one memory, one write and one read port.
`default_nettype none
module uule_store import uule_pkg::*; (
	input wire logic clk,
	input wire wr_t wr,
	input wire logic rd_en,
	input wire logic [ADDR_W-1:0] rd_addr,
	output logic [7:0] rd_data
);

	logic [7:0] mem [2**ADDR_W];

	// Write a stored byte
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Register read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/uule_front.sv =====
// Front end: accepts bytes, fills the current line buffer and closes lines.
`default_nettype none
module uule_front import uule_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic final_byte,
	output wr_t wr,
	output logic push,
	output job_t push_job,
	input wire rel_t rel
);

	logic [1:0] busy_q;
	logic bank_q;
	logic [CNT_W-1:0] count_q;
	logic accept;
	logic [CNT_W-1:0] cnt_next;
	logic close;

	// Stall while the buffer being filled still waits for the encoder
	assign in_stall = busy_q[bank_q];
	assign accept = in_valid && !busy_q[bank_q];
	assign cnt_next = count_q + CNT_W'(1);
	assign close = (cnt_next == LINE_LEN) || final_byte;

	assign wr.en = accept;
	assign wr.addr = {bank_q, count_q};
	assign wr.data = data_byte;

	assign push = accept && close;
	assign push_job.bank = bank_q;
	assign push_job.count = cnt_next;
	assign push_job.last = final_byte;

	// Advance fill position; swap buffers on a closed line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			if (close) begin
				bank_q <= !bank_q;
				count_q <= '0;
			end else begin
				count_q <= cnt_next;
			end
		end
	end

	// Mark buffers busy on close, free them on release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (push && (bank_q == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (rel.valid && (rel.bank == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/uule_jobq.sv =====
// Two-entry queue of closed lines between front end and encoder.
`default_nettype none
module uule_jobq import uule_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire job_t push_job,
	input wire logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	job_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;

	assign head = slot_q[rd_ptr_q];
	assign empty = (fill_q == 2'd0);
	assign full = (fill_q == 2'd2);

	// Store a pushed beat
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push && !full, pop && !empty})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/uule_back.sv =====
// Encoder back end: fetches byte groups from the store and emits line characters.
`default_nettype none
module uule_back import uule_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_avail,
	input wire job_t head,
	output logic pop,
	output logic rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input wire logic [7:0] rd_data,
	output rel_t rel,
	output logic out_valid,
	input wire logic out_stall,
	output logic [6:0] out_char,
	output logic run_end
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_LEN = 3'd1;
	localparam logic [2:0] B_DATA = 3'd2;
	localparam logic [2:0] B_NL = 3'd3;
	localparam logic [2:0] B_TICK = 3'd4;
	localparam logic [2:0] B_NL2 = 3'd5;

	logic [2:0] state_q;
	job_t job_q;

	// Fetch side
	logic [CNT_W-1:0] fetch_idx_q;
	logic [1:0] fetch_slot_q;
	logic pend_s1;
	logic [1:0] pend_slot_s1;
	logic pend_pad_s1;
	logic [23:0] nbuf_q;
	logic nbuf_full_q;
	logic more_fetch;
	logic [7:0] arr_byte;

	// Emit side
	logic [23:0] grp_q;
	logic grp_valid_q;
	logic [1:0] char_idx_q;
	logic [CNT_W-1:0] emit_base_q;
	logic last_grp;
	logic take;
	logic [5:0] sext;

	// Output register
	logic out_valid_q;
	logic [6:0] out_char_q;
	logic run_end_q;
	logic out_free;
	logic emit_req;
	logic fire;
	logic [6:0] emit_char;
	logic emit_end;

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign run_end = run_end_q;
	assign out_free = !out_valid_q || !out_stall;

	assign pop = (state_q == B_IDLE) && job_avail;

	// Issue a read while the group buffer has room
	assign more_fetch = (fetch_idx_q < job_q.count) || (fetch_slot_q != 2'd0);
	assign rd_en = (state_q != B_IDLE) && more_fetch && !nbuf_full_q
		&& !(pend_s1 && (pend_slot_s1 == 2'd2));
	assign rd_addr = {job_q.bank, fetch_idx_q};
	assign arr_byte = pend_pad_s1 ? 8'd0 : rd_data;

	assign take = (state_q != B_IDLE) && !grp_valid_q && nbuf_full_q;
	assign last_grp = ({1'b0, emit_base_q} + 7'd3) >= {1'b0, job_q.count};

	// Pick the six-bit field of the current group
	always_comb begin
		case (char_idx_q)
			2'd0: sext = grp_q[23:18];
			2'd1: sext = grp_q[17:12];
			2'd2: sext = grp_q[11:6];
			default: sext = grp_q[5:0];
		endcase
	end

	// Select the next character
	always_comb begin
		emit_req = 1'b0;
		emit_char = CH_NEWLINE;
		emit_end = 1'b0;
		case (state_q)
			B_LEN: begin
				emit_req = 1'b1;
				emit_char = CH_SPACE + {1'b0, job_q.count};
			end
			B_DATA: begin
				emit_req = grp_valid_q;
				emit_char = CH_SPACE + {1'b0, sext};
			end
			B_NL: begin
				emit_req = 1'b1;
				emit_char = CH_NEWLINE;
				emit_end = !job_q.last;
			end
			B_TICK: begin
				emit_req = 1'b1;
				emit_char = CH_BACKTICK;
			end
			B_NL2: begin
				emit_req = 1'b1;
				emit_char = CH_NEWLINE;
				emit_end = 1'b1;
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	assign fire = emit_req && out_free;

	// Hand the line buffer back after its last character
	assign rel.valid = fire && (((state_q == B_NL) && !job_q.last) || (state_q == B_NL2));
	assign rel.bank = job_q.bank;

	// Sequence one line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			grp_valid_q <= 1'b0;
			char_idx_q <= 2'd0;
			emit_base_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_avail) begin
						state_q <= B_LEN;
						char_idx_q <= 2'd0;
						emit_base_q <= '0;
					end
				end
				B_LEN: begin
					if (fire) begin
						state_q <= B_DATA;
					end
				end
				B_DATA: begin
					if (fire) begin
						char_idx_q <= char_idx_q + 2'd1;
						if (char_idx_q == 2'd3) begin
							if (last_grp) begin
								state_q <= B_NL;
							end else begin
								emit_base_q <= emit_base_q + CNT_W'(3);
							end
						end
					end
				end
				B_NL: begin
					if (fire) begin
						state_q <= job_q.last ? B_TICK : B_IDLE;
					end
				end
				B_TICK: begin
					if (fire) begin
						state_q <= B_NL2;
					end
				end
				B_NL2: begin
					if (fire) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			// Hold or drop the current group
			if (take) begin
				grp_valid_q <= 1'b1;
			end else if (fire && (state_q == B_DATA) && (char_idx_q == 2'd3)) begin
				grp_valid_q <= 1'b0;
			end
		end
	end

	// Load the job and the group payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (take) begin
			grp_q <= nbuf_q;
		end
	end

	// Track reads in flight and fill the group buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_idx_q <= '0;
			fetch_slot_q <= 2'd0;
			pend_s1 <= 1'b0;
			nbuf_full_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (pop) begin
				fetch_idx_q <= '0;
				fetch_slot_q <= 2'd0;
			end else if (rd_en) begin
				fetch_idx_q <= fetch_idx_q + CNT_W'(1);
				fetch_slot_q <= (fetch_slot_q == 2'd2) ? 2'd0 : fetch_slot_q + 2'd1;
			end
			if (take) begin
				nbuf_full_q <= 1'b0;
			end else if (pend_s1 && (pend_slot_s1 == 2'd2)) begin
				nbuf_full_q <= 1'b1;
			end
		end
	end

	// Place arriving bytes, most significant first
	always_ff @(posedge clk) begin
		pend_slot_s1 <= fetch_slot_q;
		pend_pad_s1 <= (fetch_idx_q >= job_q.count);
		if (pend_s1) begin
			case (pend_slot_s1)
				2'd0: nbuf_q[23:16] <= arr_byte;
				2'd1: nbuf_q[15:8] <= arr_byte;
				default: nbuf_q[7:0] <= arr_byte;
			endcase
		end
	end

	// Output register: advance when the beat is taken or the register is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit_req;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_char_q <= emit_char;
			run_end_q <= emit_end;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/uuencode_line_encoder.sv =====
// Path: the closing byte is queued, the encoder leaves idle, then the first character
// is registered. Throughput: bytes enter one per cycle while a line buffer is free;
// the encoder emits four characters per three-byte group, a length and a newline per
// line (a backtick and a newline more for the trailer); a full line holds 45 bytes;
// two line buffers let the next line fill while the current one is encoded.
// Reset: asynchronous, clears byte count, buffer ownership, queue and output valid.
`default_nettype none
module uuencode_line_encoder import uule_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic final_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [6:0] out_char,
	output logic run_end
);

	wr_t wr;
	logic push;
	job_t push_job;
	rel_t rel;
	job_t head;
	logic q_empty;
	logic q_full;
	logic pop;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0] rd_data;

	uule_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.wr(wr),
		.push(push),
		.push_job(push_job),
		.rel(rel)
	);

	uule_store u_store (
		.clk(clk),
		.wr(wr),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	uule_jobq u_jobq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.empty(q_empty),
		.full(q_full)
	);

	uule_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_avail(!q_empty),
		.head(head),
		.pop(pop),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.rel(rel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.run_end(run_end)
	);

`ifndef ASSERT_OFF
	// Buffer ownership keeps the line queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full))
		else $error("line queue overflow");

	// Every character is printable uuencode or a newline
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_char == CH_NEWLINE) ||
			((out_char >= CH_SPACE) && (out_char <= CH_BACKTICK))))
		else $error("character out of range");

	// The last character of a run is always a newline
	a_end_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && run_end) |-> (out_char == CH_NEWLINE))
		else $error("run does not end in newline");

	// A backtick is followed by the trailing newline
	a_tick_then_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && (out_char == CH_BACKTICK)) |=>
			(!out_valid || ((out_char == CH_NEWLINE) && run_end)))
		else $error("backtick not followed by final newline");
`endif

endmodule
`default_nettype wire

// ===== bench/uule_char_checker.sv =====
// Line-encoder checker: predicts every output character from the accepted bytes and compares.
`default_nettype none
module uule_char_checker import uule_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [7:0] data_byte,
	input wire logic final_byte,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [6:0] out_char,
	input wire logic run_end,
	output int fail_count,
	output int chars_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0] ch;
		logic last;
	} char_beat_t;

	// Characters still owed by the block, oldest first
	char_beat_t chars_due[$];

	// Model copy of the current line
	logic [7:0] line_held [STORE_DEPTH];
	int unsigned bytes_held;

	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		return CH_SPACE + 7'(v);
	endfunction

	task automatic owe_char(input logic [6:0] c);
		chars_due.push_back('{ch: c, last: 1'b0});
	endtask

	// Store one byte; on a closed line queue its length, groups, newline and any trailer
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		int unsigned n;
		int unsigned g;
		logic [23:0] grp;
		char_beat_t tail;
		line_held[bytes_held] = b;
		n = bytes_held + 1;
		if (n > LINE_BYTES) begin
			n = LINE_BYTES;
		end
		bytes_held = n;
		if (n == LINE_BYTES || fin) begin
			owe_char(CH_SPACE + 7'(n));
			for (g = 0; g < n; g += 3) begin
				// pad a short last group with zero bytes
				grp[23:16] = line_held[g];
				grp[15:8] = (g + 1 < n) ? line_held[g + 1] : 8'h00;
				grp[7:0] = (g + 2 < n) ? line_held[g + 2] : 8'h00;
				owe_char(sextet_char(grp[23:18]));
				owe_char(sextet_char(grp[17:12]));
				owe_char(sextet_char(grp[11:6]));
				owe_char(sextet_char(grp[5:0]));
			end
			owe_char(CH_NEWLINE);
			bytes_held = 0;
			if (fin) begin
				owe_char(CH_BACKTICK);
				owe_char(CH_NEWLINE);
			end
			// mark the last character this byte causes
			tail = chars_due.pop_back();
			tail.last = 1'b1;
			chars_due.push_back(tail);
		end
	endtask

	// Watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		char_beat_t want;
		if (!arst_n) begin
			bytes_held = 0;
			chars_due.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (chars_due.size() == 0) begin
					$error("unexpected beat: out_char=%0d run_end=%0b", out_char, run_end);
					fail_count++;
				end else begin
					want = chars_due.pop_front();
					if (out_char !== want.ch) begin
						$error("out_char: expected %0d, actual %0d", want.ch, out_char);
						fail_count++;
					end
					if (run_end !== want.last) begin
						$error("run_end: expected %0b, actual %0b", want.last, run_end);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				encode_byte(data_byte, final_byte);
			end
		end
		chars_pending = chars_due.size();
	end

endmodule
`default_nettype wire

// ===== bench/tb_uuencode_line_encoder.sv =====
// Top of the line-encoder bench: clock, reset, byte stimulus, output stalls and verdict.
`default_nettype none
module tb_uuencode_line_encoder import uule_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = 8'h00;
	logic final_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [6:0] out_char;
	logic run_end;
	int fail_count;
	int chars_pending;

	// No idling on either side while set
	bit calm = 1'b0;
	int random_bytes = 0;

	uuencode_line_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.run_end(run_end)
	);

	uule_char_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.run_end(run_end),
		.fail_count(fail_count),
		.chars_pending(chars_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one byte after a random gap and hold it until accepted; enter and leave at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Send a message of random bytes, final flag on the last one
	task automatic send_message(input int unsigned len);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
			random_bytes++;
		end
	endtask

	// Stimulus
	initial begin
		int unsigned len;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one byte: short group padded with two zeros
		send_byte(8'h00, 1'b1);
		// two bytes: one zero pad
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// one full group with extremes
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
		// full group plus a one-byte tail
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b1);
		// sextet boundaries
		send_byte(8'hFC, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3F, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h0C, 1'b1);

		// hold off until the block has drained
		in_valid <= 1'b0;
		while (chars_pending != 0) @(negedge clk);

		// random messages: exact full lines, lines that spill over, and short ones
		while (random_bytes < 130) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0: len = LINE_BYTES;
				1: len = LINE_BYTES + $urandom_range(1, 5);
				2: len = $urandom_range(1, 6);
				default: len = $urandom_range(1, LINE_BYTES - 1);
			endcase
			send_message(len);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// drain, then allow for stray beats
		while (chars_pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0 && chars_pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Output side: stall a random number of cycles before taking each beat
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	// Guard against a hang
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/uule_pkg.sv
rtl/uule_store.sv
rtl/uule_front.sv
rtl/uule_jobq.sv
rtl/uule_back.sv
rtl/uuencode_line_encoder.sv
bench/uule_char_checker.sv
bench/tb_uuencode_line_encoder.sv
